/* hdl/lrz_pkg.sv */
package lrz_pkg;

    // Entries held between the front end and the back end
    localparam int QUEUE_DEPTH = 2;

    // Command codes on the cmd field
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Back end sequencer, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } t_back_state;

endpackage

/* hdl/lrz_cmd_if.sv */
interface lrz_cmd_if #(
    parameter int COORD_BITS = 14
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;

    modport source (
        output valid, cmd, x_start, y_start, x_end, y_end,
        input  ready
    );
    modport sink (
        input  valid, cmd, x_start, y_start, x_end, y_end,
        output ready
    );
endinterface

/* hdl/lrz_pix_if.sv */
interface lrz_pix_if #(
    parameter int COORD_BITS = 14
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, last_pixel,
        output ready
    );
endinterface

/* hdl/lrz_front.sv */
// Classifies incoming transfers and works out the line geometry for loads.
module lrz_front
    import lrz_pkg::*;
#(
    parameter int COORD_BITS = 14,
    parameter int ENTRY_W    = 5 * COORD_BITS + 3
) (
    lrz_cmd_if.sink              i_cmd_ch,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output logic [ENTRY_W-1:0]   o_push_entry
);
    typedef struct packed {
        logic                         load;
        logic signed [COORD_BITS-1:0] xs;
        logic signed [COORD_BITS-1:0] ys;
        logic                         neg_x;
        logic                         neg_y;
        logic        [COORD_BITS-1:0] mag_x;
        logic        [COORD_BITS-1:0] mag_y;
        logic        [COORD_BITS-1:0] steps;
    } t_entry;

    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic        [COORD_BITS:0]   abs_x;
    logic        [COORD_BITS:0]   abs_y;
    t_entry                       entry;

    assign dx    = {i_cmd_ch.x_end[COORD_BITS-1], i_cmd_ch.x_end}
                 - {i_cmd_ch.x_start[COORD_BITS-1], i_cmd_ch.x_start};
    assign dy    = {i_cmd_ch.y_end[COORD_BITS-1], i_cmd_ch.y_end}
                 - {i_cmd_ch.y_start[COORD_BITS-1], i_cmd_ch.y_start};
    assign abs_x = dx[COORD_BITS] ? -dx : dx;
    assign abs_y = dy[COORD_BITS] ? -dy : dy;

    always_comb begin
        entry.load  = (i_cmd_ch.cmd == CMD_LOAD);
        entry.xs    = i_cmd_ch.x_start;
        entry.ys    = i_cmd_ch.y_start;
        entry.neg_x = dx[COORD_BITS];
        entry.neg_y = dy[COORD_BITS];
        // |d| never exceeds 2^COORD_BITS - 1, so the top bit is always clear
        entry.mag_x = abs_x[COORD_BITS-1:0];
        entry.mag_y = abs_y[COORD_BITS-1:0];
        entry.steps = (abs_x > abs_y) ? abs_x[COORD_BITS-1:0] : abs_y[COORD_BITS-1:0];
    end

    assign o_push_valid   = i_cmd_ch.valid;
    assign i_cmd_ch.ready = i_push_ready;
    assign o_push_entry   = entry;

endmodule

/* hdl/lrz_queue.sv */
// Small FIFO between front and back; push and pop may coincide.
module lrz_queue
    import lrz_pkg::*;
#(
    parameter int DATA_W = 73
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_pop_data
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = i_pop & o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* hdl/lrz_back.sv */
// Executes queued items: increment division on loads, pixel stepping on advances.
module lrz_back
    import lrz_pkg::*;
#(
    parameter int COORD_BITS = 14,
    parameter int FRAC_BITS  = 16,
    parameter int ENTRY_W    = 5 * COORD_BITS + 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  logic [ENTRY_W-1:0] i_q_entry,
    output logic               o_q_pop,
    lrz_pix_if.source          o_pix_ch
);
    typedef struct packed {
        logic                         load;
        logic signed [COORD_BITS-1:0] xs;
        logic signed [COORD_BITS-1:0] ys;
        logic                         neg_x;
        logic                         neg_y;
        logic        [COORD_BITS-1:0] mag_x;
        logic        [COORD_BITS-1:0] mag_y;
        logic        [COORD_BITS-1:0] steps;
    } t_entry;

    localparam int POS_W  = COORD_BITS + 1 + FRAC_BITS;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAC_BITS);

    t_entry                    entry;
    t_back_state               r_state, n_state;
    logic                      r_active, n_active;
    logic signed [POS_W-1:0]   r_pos_x, n_pos_x;
    logic signed [POS_W-1:0]   r_pos_y, n_pos_y;
    logic signed [STEP_W-1:0]  r_step_x, n_step_x;
    logic signed [STEP_W-1:0]  r_step_y, n_step_y;
    logic [COORD_BITS-1:0]     r_left, n_left;
    logic                      r_neg_x, n_neg_x;
    logic                      r_neg_y, n_neg_y;
    logic [COORD_BITS:0]       r_rem_x, n_rem_x;
    logic [COORD_BITS:0]       r_rem_y, n_rem_y;
    logic [QUO_W-1:0]          r_quo_x, n_quo_x;
    logic [QUO_W-1:0]          r_quo_y, n_quo_y;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0]     r_out_x, n_out_x;
    logic [COORD_BITS-1:0]     r_out_y, n_out_y;
    logic                      r_out_last, n_out_last;

    logic                      out_free;
    logic [COORD_BITS:0]       divisor;
    logic                      ge_x, ge_y;
    logic [COORD_BITS:0]       keep_x, keep_y;
    logic [QUO_W-1:0]          quo_x_nx, quo_y_nx;
    logic [COORD_BITS:0]       int_x, int_y;
    logic [COORD_BITS:0]       pix_x, pix_y;

    assign entry    = i_q_entry;
    assign out_free = ~r_out_valid | o_pix_ch.ready;

    // One restoring step per axis: the remainder left after the subtract stays below the step count
    assign divisor  = {1'b0, r_left};
    assign ge_x     = (r_rem_x >= divisor);
    assign ge_y     = (r_rem_y >= divisor);
    assign keep_x   = ge_x ? (r_rem_x - divisor) : r_rem_x;
    assign keep_y   = ge_y ? (r_rem_y - divisor) : r_rem_y;
    assign quo_x_nx = {r_quo_x[QUO_W-2:0], ge_x};
    assign quo_y_nx = {r_quo_y[QUO_W-2:0], ge_y};

    // Truncate toward zero: floor, plus one for a negative value with a fraction
    assign int_x = r_pos_x[POS_W-1:FRAC_BITS];
    assign int_y = r_pos_y[POS_W-1:FRAC_BITS];
    assign pix_x = int_x + {{COORD_BITS{1'b0}},
                            (r_pos_x[POS_W-1] & (|r_pos_x[FRAC_BITS-1:0]))};
    assign pix_y = int_y + {{COORD_BITS{1'b0}},
                            (r_pos_y[POS_W-1] & (|r_pos_y[FRAC_BITS-1:0]))};

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_step_x    = r_step_x;
        n_step_y    = r_step_y;
        n_left      = r_left;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        n_rem_x     = r_rem_x;
        n_rem_y     = r_rem_y;
        n_quo_x     = r_quo_x;
        n_quo_y     = r_quo_y;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~o_pix_ch.ready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (entry.load) begin
                        o_q_pop  = 1'b1;
                        n_active = 1'b1;
                        n_pos_x  = {entry.xs[COORD_BITS-1], entry.xs, {FRAC_BITS{1'b0}}};
                        n_pos_y  = {entry.ys[COORD_BITS-1], entry.ys, {FRAC_BITS{1'b0}}};
                        n_left   = entry.steps;
                        n_neg_x  = entry.neg_x;
                        n_neg_y  = entry.neg_y;
                        n_rem_x  = {1'b0, entry.mag_x};
                        n_rem_y  = {1'b0, entry.mag_y};
                        n_quo_x  = '0;
                        n_quo_y  = '0;
                        n_cnt    = '0;
                        n_step_x = '0;
                        n_step_y = '0;
                        if (entry.steps != '0) begin
                            n_state = ST_DIV;
                        end
                    end else if (!r_active) begin
                        o_q_pop = 1'b1;
                    end else if (out_free) begin
                        o_q_pop     = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_x     = pix_x[COORD_BITS-1:0];
                        n_out_y     = pix_y[COORD_BITS-1:0];
                        n_out_last  = (r_left == '0);
                        if (r_left == '0) begin
                            n_active = 1'b0;
                        end else begin
                            n_left  = r_left - 1'b1;
                            n_pos_x = r_pos_x + POS_W'(r_step_x);
                            n_pos_y = r_pos_y + POS_W'(r_step_y);
                        end
                    end
                end
            end
            ST_DIV: begin
                n_quo_x = quo_x_nx;
                n_quo_y = quo_y_nx;
                n_rem_x = {keep_x[COORD_BITS-1:0], 1'b0};
                n_rem_y = {keep_y[COORD_BITS-1:0], 1'b0};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    n_step_x = r_neg_x ? -$signed({1'b0, quo_x_nx}) : $signed({1'b0, quo_x_nx});
                    n_step_y = r_neg_y ? -$signed({1'b0, quo_y_nx}) : $signed({1'b0, quo_y_nx});
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_step_x    <= '0;
            r_step_y    <= '0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_step_x    <= n_step_x;
            r_step_y    <= n_step_y;
            r_left      <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg_x    <= n_neg_x;
        r_neg_y    <= n_neg_y;
        r_rem_x    <= n_rem_x;
        r_rem_y    <= n_rem_y;
        r_quo_x    <= n_quo_x;
        r_quo_y    <= n_quo_y;
        r_cnt      <= n_cnt;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
    end

    assign o_pix_ch.valid      = r_out_valid;
    assign o_pix_ch.pixel_x    = r_out_x;
    assign o_pix_ch.pixel_y    = r_out_y;
    assign o_pix_ch.last_pixel = r_out_last;

endmodule

/* hdl/dda_line_rasterizer_top.sv */
// DDA line rasteriser. A transfer with cmd 0 loads a line between two signed
// endpoints; each transfer with cmd 1 then yields one pixel (position truncated
// toward zero), max(|dx|,|dy|)+1 pixels per line, the final one flagged with
// last_pixel. Advances with no line loaded are swallowed without a result.
// Increments are dx and dy scaled by 2^FRAC_BITS and divided by the step
// count, truncated. Throughput: pixels stream at one per cycle while the
// output is taken. A load of a line of non-zero length runs the restoring
// divider, which produces one quotient bit per cycle for both axes; a
// zero-length line skips the division. A two-entry queue sits between the
// command side and the back end, so commands keep being accepted while a
// division runs or the output stalls, until the queue is full; the pixel
// output is registered.
module dda_line_rasterizer_top
    import lrz_pkg::*;
#(
    parameter int COORD_BITS = 14,
    parameter int FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lrz_cmd_if.sink   i_cmd_ch,
    lrz_pix_if.source o_pix_ch
);
    // load flag, two start coords, two signs, two magnitudes, step count
    localparam int ENTRY_W = 5 * COORD_BITS + 3;

    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_entry;
    logic               q_valid;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_entry;

    // Front: classify transfer, compute deltas and step count
    lrz_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_cmd_ch     (i_cmd_ch),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_entry (push_entry)
    );

    // Decoupling queue
    lrz_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_entry),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_data   (q_entry)
    );

    // Back: divider for increments, position accumulators, output register
    lrz_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .o_pix_ch  (o_pix_ch)
    );

endmodule
